>>> rtl/core/pcs_pkg.sv
// Shared types and constants for the prime counting sieve core.
// No dependencies; the other files of the core that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

    localparam int unsigned MAX_N_DEFAULT = 65535;
    localparam int unsigned LIMIT_W       = 16;
    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned FIRST_PRIME   = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the limit, clear the count
        logic fill_step;    // set mark at index, step index
        logic p_init;       // p = 2, p squared = 4
        logic p_read;       // read the mark of p
        logic p_advance;    // p = p + 1, update p squared
        logic clear_start;  // index = p squared
        logic clear_step;   // clear mark at index, index += p
        logic scan_start;   // index = 2
        logic scan_step;    // read mark at index, step index
        logic load_result;  // move the count into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_small;     // incoming limit is below two
        logic fill_last;    // index has reached n
        logic p_done;       // p squared exceeds n
        logic p_marked;     // mark of p read back as set
        logic clear_last;   // next multiple would pass n
        logic scan_last;    // index has reached n
        logic out_free;     // output register can take a result
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/pcs_if.sv
// Request and response channel interfaces of the prime counting sieve core.
// Depends on pcs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pcs_req_if;
    logic                             valid;
    logic                             ready;
    logic [pcs_pkg::LIMIT_W-1:0]      limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

interface pcs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pcs_pkg::COUNT_W-1:0]      prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/prime_count_sieve_core.sv
// Top level of the prime counting sieve core: controller, datapath and mark map.
// Depends on pcs_pkg, pcs_if, pcs_ram, pcs_ctrl and pcs_dp.
//
//  Channel  Direction  Payload              Handshake
//  req      in         limit [15:0]         valid / ready
//  rsp      out        prime_count [15:0]   valid / ready
//
// A request with limit n (saturated to MAX_N) sets map entries 0..n, then
// tests each candidate p with p*p <= n and, if its mark is still set, clears
// its multiples from p*p upward, then scans entries 2..n and counts the set
// marks; the fill and clear phases share the single map write port.
// A limit below two skips these phases and loads a count of zero instead.
// The map needs no clearing after reset, since every request writes entries
// 0..n before it reads any of them.
// A finished count waits in the output register; the core stalls only when a
// second count is ready while the first has not yet been taken.
`timescale 1ns / 1ps
`default_nettype none

module prime_count_sieve_core #(
    parameter int unsigned MAX_N = pcs_pkg::MAX_N_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pcs_req_if.sink    req,
    pcs_rsp_if.source  rsp
);

    // Map address width; the map holds entries 0 through MAX_N.
    localparam int unsigned AW = $clog2(MAX_N + 1);

    pcs_pkg::cmd_t    cmd;
    pcs_pkg::status_t stat;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic          ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic          ram_rd_data;

    // The controller walks fill, sieve and scan phases; it is ready for a new
    // request only while idle.
    pcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds n, p, p squared, the map index, the running count
    // and the output register.
    pcs_dp #(
        .MAX_N (MAX_N),
        .AW    (AW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .limit       (req.limit),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .prime_count (rsp.prime_count)
    );

    // One-bit candidate map: a mark set means the index may still be prime.
    pcs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_N + 1)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/pcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pcs_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pcs_ctrl.sv
// Sequencing state machine of the prime counting sieve core.
// Depends on pcs_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module pcs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire pcs_pkg::status_t stat,
    output pcs_pkg::cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_PTEST = 3'd2;
    localparam logic [2:0] ST_PWAIT = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_DRAIN = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_small ? ST_DONE : ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.p_init = 1'b1;
                    state_next = ST_PTEST;
                end
            end
            ST_PTEST:
            begin
                if (stat.p_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    cmd.p_read = 1'b1;
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT:
            begin
                if (stat.p_marked)
                begin
                    cmd.clear_start = 1'b1;
                    state_next      = ST_CLEAR;
                end
                else
                begin
                    cmd.p_advance = 1'b1;
                    state_next    = ST_PTEST;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    cmd.p_advance = 1'b1;
                    state_next    = ST_PTEST;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pcs_dp.sv
// Datapath of the prime counting sieve core: limit, prime, index and count
// registers, map address selection and the output register. Depends on pcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcs_dp #(
    parameter int unsigned MAX_N = pcs_pkg::MAX_N_DEFAULT,
    parameter int unsigned AW    = $clog2(MAX_N + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pcs_pkg::cmd_t                 cmd,
    output pcs_pkg::status_t                   stat,
    input  wire logic [pcs_pkg::LIMIT_W-1:0]   limit,
    output logic                               ram_wr_en,
    output logic      [AW-1:0]                 ram_wr_addr,
    output logic                               ram_wr_data,
    output logic                               ram_rd_en,
    output logic      [AW-1:0]                 ram_rd_addr,
    input  wire logic                          ram_rd_data,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic      [pcs_pkg::COUNT_W-1:0]   prime_count
);

    localparam int unsigned EW = (AW > pcs_pkg::LIMIT_W) ? AW : pcs_pkg::LIMIT_W;

    logic [AW-1:0]               n_reg;
    logic [AW-1:0]               p_reg;
    logic [AW:0]                 psq_reg;
    logic [AW:0]                 idx_reg;
    logic [pcs_pkg::COUNT_W-1:0] count_reg;
    logic [pcs_pkg::COUNT_W-1:0] out_count_reg;
    logic                        scan_vld_reg;
    logic                        out_valid_reg;

    logic [EW-1:0] limit_ext;
    logic [AW-1:0] n_in;
    logic [AW:0]   n_wide;
    logic [AW:0]   idx_plus_p;

    // Limits beyond the map saturate to its last entry.
    assign limit_ext = EW'(limit);
    assign n_in      = (limit_ext > EW'(MAX_N)) ? AW'(EW'(MAX_N)) : AW'(limit_ext);
    assign n_wide     = {1'b0, n_reg};
    assign idx_plus_p = idx_reg + {1'b0, p_reg};

    assign stat.in_small   = (limit < pcs_pkg::LIMIT_W'(pcs_pkg::FIRST_PRIME));
    assign stat.fill_last  = (idx_reg == n_wide);
    assign stat.p_done     = (psq_reg > n_wide);
    assign stat.p_marked   = ram_rd_data;
    assign stat.clear_last = (idx_plus_p > n_wide);
    assign stat.scan_last  = (idx_reg == n_wide);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign ram_wr_en   = cmd.fill_step || cmd.clear_step;
    assign ram_wr_addr = idx_reg[AW-1:0];
    assign ram_wr_data = cmd.fill_step;
    assign ram_rd_en   = cmd.p_read || cmd.scan_step;
    assign ram_rd_addr = cmd.p_read ? p_reg : idx_reg[AW-1:0];

    assign out_valid   = out_valid_reg;
    assign prime_count = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= cmd.scan_step;
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= n_in;
        end

        if (cmd.load)
        begin
            idx_reg <= '0;
        end
        else if (cmd.fill_step || cmd.scan_step)
        begin
            idx_reg <= idx_reg + (AW + 1)'(1);
        end
        else if (cmd.clear_start)
        begin
            idx_reg <= psq_reg;
        end
        else if (cmd.clear_step)
        begin
            idx_reg <= idx_plus_p;
        end
        else if (cmd.scan_start)
        begin
            idx_reg <= (AW + 1)'(pcs_pkg::FIRST_PRIME);
        end

        // (p + 1)^2 = p^2 + 2p + 1
        if (cmd.p_init)
        begin
            p_reg   <= AW'(pcs_pkg::FIRST_PRIME);
            psq_reg <= (AW + 1)'(pcs_pkg::FIRST_PRIME * pcs_pkg::FIRST_PRIME);
        end
        else if (cmd.p_advance)
        begin
            p_reg   <= p_reg + AW'(1);
            psq_reg <= psq_reg + {p_reg, 1'b1};
        end

        if (cmd.load)
        begin
            count_reg <= '0;
        end
        else if (scan_vld_reg && ram_rd_data)
        begin
            count_reg <= count_reg + pcs_pkg::COUNT_W'(1);
        end

        if (cmd.load_result)
        begin
            out_count_reg <= count_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pcs_checker.sv
// Port-level assertions for the prime counting sieve core, bound to its top.
// Depends on pcs_pkg and prime_count_sieve_core.
`timescale 1ns / 1ps
`default_nettype none

module pcs_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [pcs_pkg::COUNT_W-1:0] rsp_prime_count
);

    // A waiting result holds its value until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prime_count))
        else $error("response changed while stalled");

    // The core works on one request at a time.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // A new result appears only as the core returns to idle.
    a_rsp_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready)
        else $error("result presented while busy");

    // No result can be produced in the cycle right after a request.
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared too early");

endmodule

bind prime_count_sieve_core pcs_checker u_pcs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_prime_count (rsp.prime_count)
);

`default_nettype wire

>>> sim/prime_count_sieve_core_tb.sv
// Self-checking testbench for prime_count_sieve_core: limit requests in, prime counts out.
// Depends on pcs_pkg and pcs_if; the scoreboard predicts each count with its own sieve.
`timescale 1ns / 1ps

module prime_count_sieve_core_tb;

    import pcs_pkg::*;

    localparam int unsigned SIEVE_MAX   = MAX_N_DEFAULT;
    localparam int unsigned RANDOM_REQS = 76;
    localparam int unsigned MAX_REPORTS = 10;

    // Holds the prime counts still owed by the core, in request order, and
    // works each one out with a plain sieve over its own mark array.
    class count_scoreboard;
        bit                 marks [0:SIEVE_MAX];
        logic [COUNT_W-1:0] pending_counts [$];
        logic [LIMIT_W-1:0] pending_limits [$];
        int unsigned        checked;
        int unsigned        mismatches;
        int unsigned        unexpected;

        function logic [COUNT_W-1:0] sieve_count(logic [LIMIT_W-1:0] limit);
            int unsigned n;
            int unsigned p;
            int unsigned i;
            int unsigned total;
            n = limit;
            if (n > SIEVE_MAX)
                n = SIEVE_MAX;
            total = 0;
            if (n >= FIRST_PRIME)
            begin
                for (i = 0; i <= n; i++)
                    marks[i] = 1'b1;
                for (p = FIRST_PRIME; p * p <= n; p++)
                begin
                    if (marks[p])
                    begin
                        for (i = p * p; i <= n; i += p)
                            marks[i] = 1'b0;
                    end
                end
                for (i = FIRST_PRIME; i <= n; i++)
                begin
                    if (marks[i])
                        total++;
                end
            end
            return total[COUNT_W-1:0];
        endfunction

        function void note_request(logic [LIMIT_W-1:0] limit);
            pending_counts.push_back(sieve_count(limit));
            pending_limits.push_back(limit);
        endfunction

        function void check_count(logic [COUNT_W-1:0] actual);
            logic [COUNT_W-1:0] want;
            logic [LIMIT_W-1:0] limit;
            if (pending_counts.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("ERROR: count %0d arrived with no request outstanding", actual);
                return;
            end
            want  = pending_counts.pop_front();
            limit = pending_limits.pop_front();
            checked++;
            if (actual !== want)
            begin
                mismatches++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("ERROR: limit %0d: prime_count expected %0d, got %0d",
                             limit, want, actual);
            end
        endfunction

        function int unsigned outstanding();
            return pending_counts.size();
        endfunction

        function int unsigned failures();
            return mismatches + unexpected + pending_counts.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pcs_req_if req_ch ();
    pcs_rsp_if rsp_ch ();

    prime_count_sieve_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    count_scoreboard board;

    // Idle percentages for the request side and the count side; the stimulus
    // process moves both through the three traffic phases.
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;

    int unsigned requests_sent;
    int unsigned quick_requests;
    int unsigned largest_limit;

    // Directed limits: both values below two, the smallest primes, the
    // squares of primes (which a strict p*p < n bound would miscount) and
    // their neighbors, powers of two, and the full-range limit. The run of
    // quick requests at the front lets a finished count wait while the next
    // one is already done.
    logic [LIMIT_W-1:0] directed_limits [] = '{
        16'd0, 16'd1, 16'd0, 16'd2, 16'd3, 16'd4, 16'd5, 16'd8, 16'd9, 16'd10,
        16'd24, 16'd25, 16'd26, 16'd48, 16'd49, 16'd120, 16'd121, 16'd169,
        16'd255, 16'd256, 16'd961, 16'd1023, 16'd1024, 16'hFFFF, 16'd1
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hands one request to the core. Valid is left high after acceptance, so
    // a following request either idles (valid drops) or reuses it directly;
    // either way valid gets only one assignment per time step.
    task automatic send_request(input logic [LIMIT_W-1:0] lim);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.limit <= lim;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_request(lim);
        requests_sent++;
        if (lim < FIRST_PRIME)
            quick_requests++;
        if (lim > largest_limit)
            largest_limit = lim;
    endtask

    // Random limits stay mostly small, since a request's run time grows with
    // its limit. A few reach into the thousands, two go much higher, and a
    // share are below four to keep quick requests piling up.
    function automatic logic [LIMIT_W-1:0] pick_limit(int unsigned k);
        if (k % 50 == 25)
            return LIMIT_W'($urandom_range(4096, 20000));
        if (k % 12 == 7)
            return LIMIT_W'($urandom_range(701, 4095));
        if ($urandom_range(0, 5) == 0)
            return LIMIT_W'($urandom_range(0, 3));
        return LIMIT_W'($urandom_range(0, 700));
    endfunction

    // Count side: a count is taken at an edge where valid and ready were both
    // high just before it. Ready is redrawn once per cycle from the phase.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                board.check_count(rsp_ch.prime_count);
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Main stimulus: reset, directed requests, then random requests across
    // the three idling phases, then drain and report.
    initial
    begin
        board             = new();
        requests_sent     = 0;
        quick_requests    = 0;
        largest_limit     = 0;
        sender_idle_pct   = 30;
        receiver_idle_pct = 48;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.limit <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_limits[d])
            send_request(directed_limits[d]);

        for (int unsigned k = 0; k < RANDOM_REQS; k++)
        begin
            if (k == RANDOM_REQS / 3)
            begin
                sender_idle_pct   = 48;
                receiver_idle_pct = 30;
            end
            else if (k == 2 * RANDOM_REQS / 3)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            send_request(pick_limit(k));
        end
        req_ch.valid <= 1'b0;

        // Wait for every count owed, then a little longer than the quickest
        // request takes so that a stray extra count would still be seen.
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d limit requests (%0d below two, largest limit %0d) over three idling phases.",
                 requests_sent, quick_requests, largest_limit);
        $display("Compared %0d prime counts: %0d wrong, %0d unrequested.",
                 board.checked, board.mismatches, board.unexpected);
        if (board.failures() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // A watchdog fails the run if it goes on well past the slowest legal run.
    initial
    begin
        #60000000;
        $display("simulation failed");
        $finish;
    end

endmodule
